// ----- hw/rtl/upwind_saturation_stencil_assert.svh -----
// ----------------------------------------------------------------------------
// upwind_saturation_stencil_assert.svh
// Assertion macros for the upwind saturation stencil; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UPWIND_SATURATION_STENCIL_ASSERT_SVH
`define UPWIND_SATURATION_STENCIL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define USS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion violated");
// next-cycle implication
`define USS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion violated");
`else
`define USS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define USS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- hw/rtl/uss_pkg.sv -----
// ----------------------------------------------------------------------------
// uss_pkg
// Grid constants, item and command types, and shared helpers.
// ----------------------------------------------------------------------------
package uss_pkg;

	// Column count is a power of two: divisions by it are arithmetic shifts.
	localparam int GRID_COLS = 64;
	localparam int GRID_ROWS = 64;
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int FP_AW     = COL_W + 2;
	localparam int FP_DEPTH  = 3 * GRID_COLS;
	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int MUL_W     = DATA_W + 1;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int TERM_W    = PROD_W - FRAC_W;
	localparam int ACC_W     = TERM_W + 3;
	localparam int COURANT_W = 31;
	localparam int POS_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int FETCH_W   = 3;
	localparam logic [FETCH_W-1:0] FETCH_LAST = 3'd5;

	localparam logic signed [DATA_W-1:0] ONE_Q         = 32'sd65536;
	localparam logic [COURANT_W-1:0]     COURANT_RESET = 31'd65536;

	typedef struct packed {
		logic signed [DATA_W-1:0] vel_left;
		logic signed [DATA_W-1:0] vel_right;
		logic signed [DATA_W-1:0] vel_up;
		logic signed [DATA_W-1:0] vel_down;
		logic signed [DATA_W-1:0] mob_left;
		logic signed [DATA_W-1:0] mob_right;
		logic signed [DATA_W-1:0] mob_up;
		logic signed [DATA_W-1:0] mob_down;
		logic signed [DATA_W-1:0] frac_flow;
		logic signed [DATA_W-1:0] cap_pressure;
		logic signed [DATA_W-1:0] source_rate;
		logic signed [DATA_W-1:0] old_saturation;
	} uss_item_t;

	// line record, faces indexed left, right, up, down
	typedef struct packed {
		logic [3:0][DATA_W-1:0] vel;
		logic [3:0][DATA_W-1:0] mob;
		logic [DATA_W-1:0]      source;
		logic [DATA_W-1:0]      sat;
	} uss_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WR_FP, ST_FETCH, ST_MUL, ST_ACC,
		ST_RATE, ST_SCALE, ST_OUT, ST_WR_CELL, ST_DONE
	} uss_state_t;

	typedef enum logic [1:0] {JOB_PREV, JOB_LEFT, JOB_HERE} uss_job_t;

	typedef enum logic [2:0] {NB_OWN, NB_LEFT, NB_RIGHT, NB_UP, NB_DOWN} uss_nb_t;

	typedef enum logic [1:0] {MUL_FLOW_VEL, MUL_FLOW_MOB, MUL_MOB_DP, MUL_COURANT} uss_mul_t;

	typedef enum logic [CFG_IDX_W-1:0] {REG_BOUNDARY_MODE, REG_COURANT_FACTOR} uss_reg_t;

	typedef struct packed {
		logic             in_load;
		logic             fp_wr;
		logic             cell_wr;
		logic             rd_en;
		logic [FP_AW-1:0] fp_addr;
		logic [COL_W-1:0] cell_addr;
		logic             cap_en;
		uss_nb_t          cap_sel;
		logic             acc_clr;
		logic             acc_en;
		logic [1:0]       acc_face;
		uss_mul_t         mul_sel;
		logic [1:0]       mul_face;
		logic             rate_load;
		logic             out_load;
		logic [ROW_W-1:0] tgt_row;
		logic [COL_W-1:0] tgt_col;
		logic             last;
		logic [3:0]       face_on;
	} uss_cmd_t;

	typedef struct packed {
		logic out_free;
	} uss_status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[DATA_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/uss_in_if.sv -----
// ----------------------------------------------------------------------------
// uss_in_if
// Cell input channel: valid/ready with one grid cell per item.
// ----------------------------------------------------------------------------
interface uss_in_if;
	logic                    valid;
	logic                    ready;
	logic signed [31:0]      vel_left;
	logic signed [31:0]      vel_right;
	logic signed [31:0]      vel_up;
	logic signed [31:0]      vel_down;
	logic signed [31:0]      mob_left;
	logic signed [31:0]      mob_right;
	logic signed [31:0]      mob_up;
	logic signed [31:0]      mob_down;
	logic signed [31:0]      frac_flow;
	logic signed [31:0]      cap_pressure;
	logic signed [31:0]      source_rate;
	logic signed [31:0]      old_saturation;

	modport source (output valid, vel_left, vel_right, vel_up, vel_down, mob_left,
		mob_right, mob_up, mob_down, frac_flow, cap_pressure, source_rate,
		old_saturation, input ready);
	modport sink (input valid, vel_left, vel_right, vel_up, vel_down, mob_left,
		mob_right, mob_up, mob_down, frac_flow, cap_pressure, source_rate,
		old_saturation, output ready);
endinterface

// ----- hw/rtl/uss_out_if.sv -----
// ----------------------------------------------------------------------------
// uss_out_if
// Result channel: valid/ready with one updated cell per item.
// ----------------------------------------------------------------------------
interface uss_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_saturation;
	logic [5:0]         out_row;
	logic [5:0]         out_col;
	logic               frame_end;

	modport source (output valid, new_saturation, out_row, out_col, frame_end,
		input ready);
	modport sink (input valid, new_saturation, out_row, out_col, frame_end,
		output ready);
endinterface

// ----- hw/rtl/uss_cfg_if.sv -----
// ----------------------------------------------------------------------------
// uss_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface uss_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [30:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/uss_ram.sv -----
// ----------------------------------------------------------------------------
// uss_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ----- hw/rtl/uss_ctrl.sv -----
// ----------------------------------------------------------------------------
// uss_ctrl
// Sequencer: raster counters, result jobs, fetch and multiply steps.
// ----------------------------------------------------------------------------
`include "upwind_saturation_stencil_assert.svh"

module uss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  uss_pkg::uss_status_t  status,
	output uss_pkg::uss_cmd_t     cmd
);

	uss_pkg::uss_state_t        state_q, state_d;
	uss_pkg::uss_job_t          job_q, job_d;
	logic [uss_pkg::FETCH_W-1:0] k_q, k_d;
	logic [1:0]                 face_q, face_d;
	logic [1:0]                 ph_q, ph_d;
	logic [uss_pkg::ROW_W-1:0]  row_q;
	logic [uss_pkg::COL_W-1:0]  col_q;
	logic [1:0]                 slot_q;

	logic                       last_row, last_col;
	logic [uss_pkg::ROW_W-1:0]  tr;
	logic [uss_pkg::COL_W-1:0]  tc;
	logic [1:0]                 s_own, s_up, s_dn;

	function automatic logic [1:0] inc3(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic logic [1:0] dec3(input logic [1:0] s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	assign last_row = (row_q == uss_pkg::ROW_W'(uss_pkg::GRID_ROWS - 1));
	assign last_col = (col_q == uss_pkg::COL_W'(uss_pkg::GRID_COLS - 1));

	// target cell and line slots of the current job
	always_comb begin
		unique case (job_q)
			uss_pkg::JOB_PREV: begin
				tr    = row_q - 1'b1;
				tc    = col_q;
				s_own = dec3(slot_q);
				s_up  = inc3(slot_q);
				s_dn  = slot_q;
			end
			uss_pkg::JOB_LEFT: begin
				tr    = row_q;
				tc    = col_q - 1'b1;
				s_own = slot_q;
				s_up  = dec3(slot_q);
				s_dn  = inc3(slot_q);
			end
			default: begin
				tr    = row_q;
				tc    = col_q;
				s_own = slot_q;
				s_up  = dec3(slot_q);
				s_dn  = inc3(slot_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uss_pkg::ST_IDLE;
			job_q   <= uss_pkg::JOB_PREV;
			k_q     <= '0;
			face_q  <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			k_q     <= k_d;
			face_q  <= face_d;
			ph_q    <= ph_d;
		end
	end

	// advance raster position once all results of an item are out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (state_q == uss_pkg::ST_DONE) begin
			if (last_col) begin
				col_q  <= '0;
				row_q  <= last_row ? '0 : row_q + 1'b1;
				slot_q <= last_row ? 2'd0 : inc3(slot_q);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		k_d     = k_q;
		face_d  = face_q;
		ph_d    = ph_q;
		unique case (state_q)
			uss_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = uss_pkg::ST_WR_FP;
			end
			uss_pkg::ST_WR_FP: begin
				if (row_q != '0) begin
					job_d   = uss_pkg::JOB_PREV;
					k_d     = '0;
					state_d = uss_pkg::ST_FETCH;
				end else begin
					state_d = uss_pkg::ST_WR_CELL;
				end
			end
			uss_pkg::ST_FETCH: begin
				if (k_q == uss_pkg::FETCH_LAST) begin
					face_d  = '0;
					ph_d    = '0;
					state_d = uss_pkg::ST_MUL;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			uss_pkg::ST_MUL: begin
				if (ph_q == 2'd2) begin
					ph_d = '0;
					if (face_q == 2'd3)
						state_d = uss_pkg::ST_ACC;
					else
						face_d = face_q + 1'b1;
				end else begin
					ph_d = ph_q + 1'b1;
				end
			end
			uss_pkg::ST_ACC:   state_d = uss_pkg::ST_RATE;
			uss_pkg::ST_RATE:  state_d = uss_pkg::ST_SCALE;
			uss_pkg::ST_SCALE: state_d = uss_pkg::ST_OUT;
			uss_pkg::ST_OUT: begin
				if (status.out_free) begin
					k_d = '0;
					unique case (job_q)
						uss_pkg::JOB_PREV: state_d = uss_pkg::ST_WR_CELL;
						uss_pkg::JOB_LEFT: begin
							if (last_col) begin
								job_d   = uss_pkg::JOB_HERE;
								state_d = uss_pkg::ST_FETCH;
							end else begin
								state_d = uss_pkg::ST_DONE;
							end
						end
						default: state_d = uss_pkg::ST_DONE;
					endcase
				end
			end
			uss_pkg::ST_WR_CELL: begin
				k_d = '0;
				if (last_row && col_q != '0) begin
					job_d   = uss_pkg::JOB_LEFT;
					state_d = uss_pkg::ST_FETCH;
				end else if (last_row && last_col) begin
					job_d   = uss_pkg::JOB_HERE;
					state_d = uss_pkg::ST_FETCH;
				end else begin
					state_d = uss_pkg::ST_DONE;
				end
			end
			uss_pkg::ST_DONE: state_d = uss_pkg::ST_IDLE;
			default:          state_d = uss_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		cmd.tgt_row  = tr;
		cmd.tgt_col  = tc;
		cmd.last     = (job_q == uss_pkg::JOB_HERE);
		cmd.face_on  = {tr != uss_pkg::ROW_W'(uss_pkg::GRID_ROWS - 1), tr != '0,
			tc != uss_pkg::COL_W'(uss_pkg::GRID_COLS - 1), tc != '0};
		cmd.cell_addr = tc;
		unique case (state_q)
			uss_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			uss_pkg::ST_WR_FP: begin
				cmd.fp_wr   = 1'b1;
				cmd.fp_addr = {slot_q, col_q};
			end
			uss_pkg::ST_FETCH: begin
				cmd.acc_clr = (k_q == '0);
				if (k_q != uss_pkg::FETCH_LAST) begin
					cmd.rd_en = 1'b1;
					unique case (uss_pkg::uss_nb_t'(k_q))
						uss_pkg::NB_OWN:   cmd.fp_addr = {s_own, tc};
						uss_pkg::NB_LEFT:  cmd.fp_addr = {s_own, tc - 1'b1};
						uss_pkg::NB_RIGHT: cmd.fp_addr = {s_own, tc + 1'b1};
						uss_pkg::NB_UP:    cmd.fp_addr = {s_up, tc};
						default:           cmd.fp_addr = {s_dn, tc};
					endcase
				end
				if (k_q != '0) begin
					cmd.cap_en  = 1'b1;
					cmd.cap_sel = uss_pkg::uss_nb_t'(k_q - 1'b1);
				end
			end
			uss_pkg::ST_MUL: begin
				cmd.mul_face = face_q;
				unique case (ph_q)
					2'd0:    cmd.mul_sel = uss_pkg::MUL_FLOW_VEL;
					2'd1:    cmd.mul_sel = uss_pkg::MUL_FLOW_MOB;
					default: cmd.mul_sel = uss_pkg::MUL_MOB_DP;
				endcase
				// sum the product issued one step back
				if (ph_q == 2'd1) begin
					cmd.acc_en   = 1'b1;
					cmd.acc_face = face_q;
				end else if (ph_q == 2'd0 && face_q != 2'd0) begin
					cmd.acc_en   = 1'b1;
					cmd.acc_face = face_q - 1'b1;
				end
			end
			uss_pkg::ST_ACC: begin
				cmd.acc_en   = 1'b1;
				cmd.acc_face = 2'd3;
			end
			uss_pkg::ST_RATE:    cmd.rate_load = 1'b1;
			uss_pkg::ST_SCALE:   cmd.mul_sel   = uss_pkg::MUL_COURANT;
			uss_pkg::ST_OUT: begin
				// hold the scaled product while the result waits for room
				cmd.mul_sel  = uss_pkg::MUL_COURANT;
				cmd.out_load = status.out_free;
			end
			uss_pkg::ST_WR_CELL: begin
				cmd.cell_wr   = 1'b1;
				cmd.cell_addr = col_q;
			end
			default: begin
			end
		endcase
	end

	`USS_ASSERT_IMP(a_load_needs_room, clk, arst_n, cmd.out_load, status.out_free)
	`USS_ASSERT_NXT(a_accept_writes_line, clk, arst_n, cmd.in_load, state_q == uss_pkg::ST_WR_FP)
	`USS_ASSERT_IMP(a_no_rw_clash, clk, arst_n, cmd.fp_wr, !cmd.rd_en && !cmd.cap_en)

endmodule

// ----- hw/rtl/uss_dp.sv -----
// ----------------------------------------------------------------------------
// uss_dp
// Datapath: line memories, neighbor registers, shared multiplier, result.
// ----------------------------------------------------------------------------
module uss_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  uss_pkg::uss_cmd_t                cmd,
	output uss_pkg::uss_status_t             status,
	input  uss_pkg::uss_item_t               in_item,
	input  logic                             boundary_mode,
	input  logic [uss_pkg::COURANT_W-1:0]    courant_factor,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [uss_pkg::DATA_W-1:0] out_sat,
	output logic [uss_pkg::POS_W-1:0]        out_row,
	output logic [uss_pkg::POS_W-1:0]        out_col,
	output logic                             out_last
);

	localparam int REC_W = $bits(uss_pkg::uss_rec_t);
	localparam int FP_W  = 2 * uss_pkg::DATA_W;

	uss_pkg::uss_item_t                 in_q;
	uss_pkg::uss_rec_t                  rec_wr, rec_q;
	logic [REC_W-1:0]                   rec_rd;
	logic [FP_W-1:0]                    fp_rd;
	logic signed [uss_pkg::DATA_W-1:0]  own_f_q, own_p_q;
	logic signed [uss_pkg::DATA_W-1:0]  nbr_f_q [4];
	logic signed [uss_pkg::DATA_W-1:0]  dp_q [4];
	logic signed [uss_pkg::PROD_W-1:0]  prod_s1;
	logic signed [uss_pkg::ACC_W-1:0]   acc_q;
	logic signed [uss_pkg::DATA_W-1:0]  rate_q;
	logic                               out_valid_q;

	logic signed [uss_pkg::DATA_W-1:0]  rd_flow, rd_pres, v_face, m_face, f_face;
	logic signed [uss_pkg::TERM_W-1:0]  term;
	logic signed [uss_pkg::MUL_W-1:0]   op_a, op_b;
	logic signed [uss_pkg::ACC_W:0]     neg_acc, a1;
	logic signed [uss_pkg::DATA_W-1:0]  a2, sat_v;
	logic [1:0]                         cap_face;
	logic                               pinned;

	always_ff @(posedge clk) begin
		if (cmd.in_load)
			in_q <= in_item;
	end

	always_comb begin
		rec_wr.vel    = {in_q.vel_down, in_q.vel_up, in_q.vel_right, in_q.vel_left};
		rec_wr.mob    = {in_q.mob_down, in_q.mob_up, in_q.mob_right, in_q.mob_left};
		rec_wr.source = in_q.source_rate;
		rec_wr.sat    = in_q.old_saturation;
	end

	uss_ram #(.WIDTH(REC_W), .DEPTH(uss_pkg::GRID_COLS)) u_cell_ram (
		.clk     (clk),
		.wr_en   (cmd.cell_wr),
		.wr_addr (cmd.cell_addr),
		.wr_data (rec_wr),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.cell_addr),
		.rd_data (rec_rd)
	);

	uss_ram #(.WIDTH(FP_W), .DEPTH(uss_pkg::FP_DEPTH)) u_fp_ram (
		.clk     (clk),
		.wr_en   (cmd.fp_wr),
		.wr_addr (cmd.fp_addr),
		.wr_data ({in_q.frac_flow, in_q.cap_pressure}),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.fp_addr),
		.rd_data (fp_rd)
	);

	assign rd_flow  = fp_rd[FP_W-1:uss_pkg::DATA_W];
	assign rd_pres  = fp_rd[uss_pkg::DATA_W-1:0];
	assign cap_face = 2'(cmd.cap_sel - 3'd1);

	// own cell arrives first, then the four neighbors
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			if (cmd.cap_sel == uss_pkg::NB_OWN) begin
				own_f_q <= rd_flow;
				own_p_q <= rd_pres;
				rec_q   <= rec_rd;
			end else begin
				nbr_f_q[cap_face] <= rd_flow;
				dp_q[cap_face]    <= uss_pkg::sat32(64'(rd_pres) - 64'(own_p_q));
			end
		end
	end

	// upwind pick: positive velocity takes own flow, negative the neighbor
	always_comb begin
		v_face = rec_q.vel[cmd.mul_face];
		m_face = rec_q.mob[cmd.mul_face];
		if (v_face > 0)
			f_face = own_f_q;
		else if (v_face < 0)
			f_face = nbr_f_q[cmd.mul_face];
		else
			f_face = '0;
	end

	assign term = prod_s1[uss_pkg::PROD_W-1:uss_pkg::FRAC_W];

	always_comb begin
		case (cmd.mul_sel)
			uss_pkg::MUL_FLOW_VEL: begin
				op_a = uss_pkg::MUL_W'(f_face);
				op_b = uss_pkg::MUL_W'(v_face);
			end
			uss_pkg::MUL_FLOW_MOB: begin
				op_a = uss_pkg::MUL_W'(f_face);
				op_b = uss_pkg::MUL_W'(m_face);
			end
			uss_pkg::MUL_MOB_DP: begin
				op_a = uss_pkg::MUL_W'(uss_pkg::sat32(64'(term)));
				op_b = uss_pkg::MUL_W'(dp_q[cmd.mul_face]);
			end
			uss_pkg::MUL_COURANT: begin
				op_a = {2'b00, courant_factor};
				op_b = uss_pkg::MUL_W'(rate_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_en && cmd.face_on[cmd.acc_face])
			acc_q <= acc_q + uss_pkg::ACC_W'(term);
	end

	assign neg_acc = -(uss_pkg::ACC_W + 1)'(acc_q);
	assign a1      = neg_acc >>> uss_pkg::COL_W;
	assign a2      = $signed(rec_q.source) >>> (2 * uss_pkg::COL_W);

	always_ff @(posedge clk) begin
		if (cmd.rate_load)
			rate_q <= uss_pkg::sat32(64'(a1) + 64'(a2));
	end

	assign pinned = (boundary_mode && cmd.tgt_row == '0 && cmd.tgt_col == '0)
		|| (!boundary_mode && cmd.tgt_col == '0);
	assign sat_v  = pinned ? uss_pkg::ONE_Q
		: uss_pkg::sat32(64'($signed(rec_q.sat)) + 64'(term));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sat  <= sat_v;
			out_row  <= 6'(cmd.tgt_row);
			out_col  <= 6'(cmd.tgt_col);
			out_last <= cmd.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

// ----- hw/rtl/upwind_saturation_stencil.sv -----
// ----------------------------------------------------------------------------
// upwind_saturation_stencil
// Explicit upwind saturation update over a raster-ordered cell stream.
// ----------------------------------------------------------------------------
// Cells of a 64 x 64 grid enter in raster order, one item per cell, and each
// updated saturation leaves one row later: a cell of row r releases the
// result of the cell above it, and on the last row each cell also releases
// its left neighbor, the last cell releasing itself with frame_end set. Each
// item is written to the line memory, then each of its results is fetched,
// multiplied, scaled and sent; no new cell is taken until its last is out.
// Per-result work is set by the single read port of the flow and pressure
// line memory (five reads for a cell and its neighbors) and by the one
// 33 x 33 multiplier, which runs three products per face and the final time
// step scaling. Configuration writes are always taken and must land while
// the block is idle. boundary_mode 1 pins only the top-left cell to 1.0,
// 0 pins the whole left column; courant_factor is unsigned Q15.16.
// ----------------------------------------------------------------------------
module upwind_saturation_stencil (
	input  logic  clk,
	input  logic  arst_n,
	uss_cfg_if.sink   cfg,
	uss_in_if.sink    cells,
	uss_out_if.source results
);

	uss_pkg::uss_cmd_t                 cmd;
	uss_pkg::uss_status_t              status;
	uss_pkg::uss_item_t                item;
	logic                              boundary_mode_q;
	logic [uss_pkg::COURANT_W-1:0]     courant_factor_q;

	// register file: always ready, written by index
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_mode_q  <= 1'b1;
			courant_factor_q <= uss_pkg::COURANT_RESET;
		end else if (cfg.valid) begin
			unique case (uss_pkg::uss_reg_t'(cfg.index))
				uss_pkg::REG_BOUNDARY_MODE:  boundary_mode_q  <= cfg.data[0];
				uss_pkg::REG_COURANT_FACTOR: courant_factor_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// gather the cell fields into one item
	always_comb begin
		item.vel_left       = cells.vel_left;
		item.vel_right      = cells.vel_right;
		item.vel_up         = cells.vel_up;
		item.vel_down       = cells.vel_down;
		item.mob_left       = cells.mob_left;
		item.mob_right      = cells.mob_right;
		item.mob_up         = cells.mob_up;
		item.mob_down       = cells.mob_down;
		item.frac_flow      = cells.frac_flow;
		item.cap_pressure   = cells.cap_pressure;
		item.source_rate    = cells.source_rate;
		item.old_saturation = cells.old_saturation;
	end

	uss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cells.valid),
		.in_ready (cells.ready),
		.status   (status),
		.cmd      (cmd)
	);

	uss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_item        (item),
		.boundary_mode  (boundary_mode_q),
		.courant_factor (courant_factor_q),
		.out_valid      (results.valid),
		.out_ready      (results.ready),
		.out_sat        (results.new_saturation),
		.out_row        (results.out_row),
		.out_col        (results.out_col),
		.out_last       (results.frame_end)
	);

endmodule
